// ===== rtl/msdme_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdme_pkg
// Shared types and constants of the despike, median and EMA filter.
// ----------------------------------------------------------------------------
package msdme_pkg;

   localparam int SAMPLE_W   = 32;
   localparam int WEIGHT_W   = 16;
   localparam int TYPE_W     = 8;
   localparam int ID_W       = 8;
   localparam int DIVIDEND_W = 33;
   localparam int DIVISOR_W  = 32;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd9830;

   localparam logic [TYPE_W-1:0] TYPE_PH         = 8'd1;
   localparam logic [TYPE_W-1:0] TYPE_2          = 8'd2;
   localparam logic [TYPE_W-1:0] TYPE_3          = 8'd3;
   localparam logic [TYPE_W-1:0] TYPE_4          = 8'd4;
   localparam logic [TYPE_W-1:0] TYPE_5          = 8'd5;
   localparam logic [TYPE_W-1:0] TYPE_6          = 8'd6;
   localparam logic [TYPE_W-1:0] TYPE_ULTRASONIC = 8'd7;

   typedef struct packed {
      logic load;
      logic scan;
      logic prime;
      logic limit;
      logic hist;
      logic mul;
      logic add;
      logic div_start;
      logic div_wait;
      logic write;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic scan_prime;
      logic prime_last;
      logic hist_done;
      logic time_adv;
      logic div_done;
      logic out_free;
   } ctrl_sts_type;

   // Maximum jump per sample, Q16.16.
   function automatic logic [SAMPLE_W-1:0] max_jump(input logic [TYPE_W-1:0] kind);
      logic [SAMPLE_W-1:0] j;
      case (kind)
         TYPE_PH:         j = 32'd131072;
         TYPE_2:          j = 32'd6553600;
         TYPE_3:          j = 32'd65536000;
         TYPE_4:          j = 32'd196608;
         TYPE_5:          j = 32'd327680;
         TYPE_6:          j = 32'd3276800;
         TYPE_ULTRASONIC: j = 32'd3276800;
         default:         j = 32'd1310720;
      endcase
      return j;
   endfunction

endpackage

// ===== rtl/msdme_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msdme_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/msdme_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdme_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msdme_divider
   import msdme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = DIVISOR_W'(shifted - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/msdme_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdme_datapath
// Record lookup, slew limit, window sort, EMA and rate, output register.
// ----------------------------------------------------------------------------
module msdme_datapath
   import msdme_pkg::*;
#(
   parameter int RECORDS = 32,
   parameter int WINDOW  = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [TYPE_W-1:0]          req_sensor_type,
   input  logic [ID_W-1:0]            req_sensor_id,
   input  logic signed [SAMPLE_W-1:0] req_raw_sample,
   input  logic [SAMPLE_W-1:0]        req_time_seconds,
   input  logic                       csr_write_enable,
   input  logic [WEIGHT_W-1:0]        csr_write_data,
   input  ctrl_cmd_type               cmd,
   output ctrl_sts_type               sts,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_level,
   output logic signed [SAMPLE_W-1:0] rsp_change_rate
);

   localparam int RW    = RECORDS > 1 ? $clog2(RECORDS) : 1;
   localparam int CW    = $clog2(RECORDS + 1);
   localparam int HD    = RECORDS * WINDOW;
   localparam int HAW   = HD > 1 ? $clog2(HD) : 1;
   localparam int FW    = $clog2(WINDOW + 1);
   localparam int SW    = WINDOW > 1 ? $clog2(WINDOW) : 1;
   localparam int REC_W = 5 * SAMPLE_W + FW + SW;
   localparam int KEY_W = TYPE_W + ID_W;
   localparam logic [SW-1:0] SLOT_PRIME = SW'(1 % WINDOW);
   localparam logic [CW-1:0] COUNT_FULL = CW'(RECORDS);
   localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
   localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

   // input transaction
   logic [TYPE_W-1:0]          type_ff;
   logic [ID_W-1:0]            id_ff;
   logic signed [SAMPLE_W-1:0] raw_ff;
   logic [SAMPLE_W-1:0]        now_ff;
   logic [WEIGHT_W-1:0]        weight_ff;

   // lookup
   logic [CW-1:0] count_ff, scan_idx_ff;
   logic          chk_valid_ff;
   logic [RW-1:0] chk_idx_ff, r_ff;
   logic [KEY_W-1:0] key_rdata;
   logic          hit, miss_end, full;

   // record fields
   logic signed [SAMPLE_W-1:0] last_ff, ema_ff, pe_ff, rate_ff;
   logic [SAMPLE_W-1:0]        pt_ff;
   logic [FW-1:0]              fill_ff;
   logic [SW-1:0]              slot_ff;
   logic [REC_W-1:0]           rec_rdata, rec_wdata;
   logic signed [SAMPLE_W-1:0] rd_last, rd_ema, rd_pe, rd_rate;
   logic [SAMPLE_W-1:0]        rd_pt;
   logic [FW-1:0]              rd_fill;
   logic [SW-1:0]              rd_slot;

   // history and sorting
   logic [HAW-1:0]             hbase, h_waddr, h_raddr;
   logic                       h_we;
   logic [SAMPLE_W-1:0]        h_wdata, h_rdata;
   logic [FW-1:0]              k_ff, n_ff;
   logic                       pend_ff;
   logic signed [SAMPLE_W-1:0] sorted_ff [WINDOW];
   logic signed [SAMPLE_W-1:0] sorted_in [WINDOW];
   logic signed [SAMPLE_W-1:0] key, med;

   // arithmetic
   logic signed [SAMPLE_W:0]   diff;
   logic signed [SAMPLE_W+1:0] clip;
   logic signed [SAMPLE_W-1:0] acc;
   logic signed [SAMPLE_W+1:0] jump;
   logic signed [49:0]         prod_ff;
   logic signed [35:0]         sum;
   logic signed [SAMPLE_W:0]   dema;
   logic                       neg_ff;
   logic [DIVIDEND_W-1:0]      mag, quo;
   logic [DIVISOR_W-1:0]       dt;
   logic                       div_done;
   logic signed [35:0]         q_signed;
   logic signed [SAMPLE_W-1:0] rate_sat;

   // output register
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] out_level_ff, out_rate_ff;

   msdme_ram #(.WIDTH(KEY_W), .DEPTH(RECORDS)) u_key_ram (
      .clock (clock),
      .we    (cmd.scan && miss_end && !full),
      .waddr (count_ff[RW-1:0]),
      .wdata ({type_ff, id_ff}),
      .raddr (scan_idx_ff[RW-1:0]),
      .rdata (key_rdata)
   );

   msdme_ram #(.WIDTH(REC_W), .DEPTH(RECORDS)) u_rec_ram (
      .clock (clock),
      .we    (cmd.write),
      .waddr (r_ff),
      .wdata (rec_wdata),
      .raddr (r_ff),
      .rdata (rec_rdata)
   );

   msdme_ram #(.WIDTH(SAMPLE_W), .DEPTH(HD)) u_hist_ram (
      .clock (clock),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   msdme_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag),
      .divisor  (dt),
      .done     (div_done),
      .quotient (quo)
   );

   assign full     = (count_ff == COUNT_FULL);
   assign hit      = cmd.scan && chk_valid_ff && (key_rdata == {type_ff, id_ff});
   assign miss_end = cmd.scan && !hit && (scan_idx_ff == count_ff);

   assign {rd_last, rd_ema, rd_pe, rd_pt, rd_rate, rd_fill, rd_slot} = rec_rdata;
   assign rec_wdata = {last_ff, ema_ff, pe_ff, pt_ff, rate_ff, fill_ff, slot_ff};

   assign hbase = HAW'(r_ff) * HAW'(WINDOW);

   // slew limit against the stored last accepted value
   always_comb begin
      jump = $signed({2'b00, max_jump(type_ff)});
      diff = $signed({raw_ff[SAMPLE_W-1], raw_ff}) - $signed({rd_last[SAMPLE_W-1], rd_last});
      clip = $signed({{2{rd_last[SAMPLE_W-1]}}, rd_last});
      acc  = raw_ff;
      if ($signed({diff[SAMPLE_W], diff}) > jump) begin
         clip = clip + jump;
         acc  = (clip > $signed(S32_MAX[SAMPLE_W+1:0])) ? S32_MAX[SAMPLE_W-1:0]
                                                        : clip[SAMPLE_W-1:0];
      end else if ($signed({diff[SAMPLE_W], diff}) < -jump) begin
         clip = clip - jump;
         acc  = (clip < $signed(S32_MIN[SAMPLE_W+1:0])) ? S32_MIN[SAMPLE_W-1:0]
                                                        : clip[SAMPLE_W-1:0];
      end
   end

   // history port selection
   always_comb begin
      h_we    = 1'b0;
      h_waddr = HAW'(hbase + HAW'(k_ff));
      h_wdata = raw_ff;
      if (cmd.prime) begin
         h_we = 1'b1;
      end else if (cmd.limit) begin
         h_we    = 1'b1;
         h_waddr = HAW'(hbase + HAW'(rd_slot));
         h_wdata = acc;
      end
      h_raddr = HAW'(hbase + HAW'(k_ff));
   end

   // insert one value into the sorted lanes
   always_comb begin
      key = h_rdata;
      for (int j = 0; j < WINDOW; j++) begin
         sorted_in[j] = sorted_ff[j];
         if (FW'(j) < n_ff) begin
            if (sorted_ff[j] > key) begin
               if (j > 0 && sorted_ff[(j > 0) ? j - 1 : 0] > key) begin
                  sorted_in[j] = sorted_ff[(j > 0) ? j - 1 : 0];
               end else begin
                  sorted_in[j] = key;
               end
            end
         end else if (FW'(j) == n_ff) begin
            if (j > 0 && sorted_ff[(j > 0) ? j - 1 : 0] > key) begin
               sorted_in[j] = sorted_ff[(j > 0) ? j - 1 : 0];
            end else begin
               sorted_in[j] = key;
            end
         end
      end
      med = sorted_ff[SW'(fill_ff >> 1)];
   end

   assign sum  = $signed({{4{ema_ff[SAMPLE_W-1]}}, ema_ff}) + 36'(prod_ff >>> 16);
   assign dema = $signed({ema_ff[SAMPLE_W-1], ema_ff}) - $signed({pe_ff[SAMPLE_W-1], pe_ff});
   assign mag  = dema[SAMPLE_W] ? DIVIDEND_W'(-dema) : DIVIDEND_W'(dema);
   assign dt   = now_ff - pt_ff;

   always_comb begin
      q_signed = neg_ff ? -$signed({3'b000, quo}) : $signed({3'b000, quo});
      if (q_signed > S32_MAX) begin
         rate_sat = S32_MAX[SAMPLE_W-1:0];
      end else if (q_signed < S32_MIN) begin
         rate_sat = S32_MIN[SAMPLE_W-1:0];
      end else begin
         rate_sat = q_signed[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff    <= WEIGHT_RESET;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         chk_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            weight_ff <= csr_write_data;
         end
         if (cmd.load) begin
            scan_idx_ff  <= '0;
            chk_valid_ff <= 1'b0;
         end else if (cmd.scan && !hit && !miss_end) begin
            chk_valid_ff <= 1'b1;
            scan_idx_ff  <= scan_idx_ff + 1'b1;
         end
         if (miss_end && !full) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.limit) begin
            pend_ff <= 1'b0;
         end else if (cmd.hist) begin
            pend_ff <= (k_ff < fill_ff);
         end
         if (cmd.write) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_sensor_type;
         id_ff   <= req_sensor_id;
         raw_ff  <= req_raw_sample;
         now_ff  <= req_time_seconds;
         k_ff    <= '0;
      end
      if (cmd.scan && !hit && !miss_end) begin
         chk_idx_ff <= scan_idx_ff[RW-1:0];
      end
      if (hit) begin
         r_ff <= chk_idx_ff;
      end else if (miss_end) begin
         r_ff <= full ? '0 : count_ff[RW-1:0];
      end
      if (cmd.prime) begin
         last_ff <= raw_ff;
         ema_ff  <= raw_ff;
         pe_ff   <= raw_ff;
         pt_ff   <= now_ff;
         rate_ff <= '0;
         fill_ff <= FW'(1);
         slot_ff <= SLOT_PRIME;
         k_ff    <= k_ff + 1'b1;
      end
      if (cmd.limit) begin
         last_ff <= acc;
         ema_ff  <= rd_ema;
         pe_ff   <= rd_pe;
         pt_ff   <= rd_pt;
         rate_ff <= rd_rate;
         fill_ff <= (rd_fill < FW'(WINDOW)) ? FW'(rd_fill + 1'b1) : rd_fill;
         slot_ff <= (rd_slot == SW'(WINDOW - 1)) ? '0 : SW'(rd_slot + 1'b1);
         k_ff    <= '0;
         n_ff    <= '0;
      end
      if (cmd.hist) begin
         if (pend_ff) begin
            for (int j = 0; j < WINDOW; j++) begin
               sorted_ff[j] <= sorted_in[j];
            end
            n_ff <= n_ff + 1'b1;
         end
         if (k_ff < fill_ff) begin
            k_ff <= k_ff + 1'b1;
         end
      end
      if (cmd.mul) begin
         prod_ff <= $signed({1'b0, weight_ff})
                    * ($signed({med[SAMPLE_W-1], med}) - $signed({ema_ff[SAMPLE_W-1], ema_ff}));
      end
      if (cmd.add) begin
         if (sum > S32_MAX) begin
            ema_ff <= S32_MAX[SAMPLE_W-1:0];
         end else if (sum < S32_MIN) begin
            ema_ff <= S32_MIN[SAMPLE_W-1:0];
         end else begin
            ema_ff <= sum[SAMPLE_W-1:0];
         end
         pt_ff <= pt_ff;
      end
      if (cmd.div_start) begin
         neg_ff <= dema[SAMPLE_W];
      end
      if (cmd.div_wait && div_done) begin
         rate_ff <= rate_sat;
         pe_ff   <= ema_ff;
         pt_ff   <= now_ff;
      end
      if (cmd.write) begin
         out_level_ff <= ema_ff;
         out_rate_ff  <= rate_ff;
      end
   end

   always_comb begin
      sts.scan_done  = hit || miss_end;
      sts.scan_prime = miss_end && !full;
      sts.prime_last = (k_ff == FW'(WINDOW - 1));
      sts.hist_done  = (k_ff == fill_ff) && !pend_ff;
      sts.time_adv   = (now_ff > pt_ff);
      sts.div_done   = div_done;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_level = out_level_ff;
   assign rsp_change_rate    = out_rate_ff;

endmodule

// ===== rtl/msdme_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msdme_controller
// Sequencer for lookup, priming, update, divide and result hand-off.
// ----------------------------------------------------------------------------
module msdme_controller
   import msdme_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SCAN     = 4'd1;
   localparam logic [3:0] ST_PRIME    = 4'd2;
   localparam logic [3:0] ST_REC_WAIT = 4'd3;
   localparam logic [3:0] ST_LIMIT    = 4'd4;
   localparam logic [3:0] ST_HIST     = 4'd5;
   localparam logic [3:0] ST_MUL      = 4'd6;
   localparam logic [3:0] ST_ADD      = 4'd7;
   localparam logic [3:0] ST_DIV_GO   = 4'd8;
   localparam logic [3:0] ST_DIV_WAIT = 4'd9;
   localparam logic [3:0] ST_WRITE    = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = sts.scan_prime ? ST_PRIME : ST_REC_WAIT;
            end
         end
         ST_PRIME: begin
            cmd.prime = 1'b1;
            if (sts.prime_last) begin
               state_in = ST_WRITE;
            end
         end
         ST_REC_WAIT: begin
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            state_in  = ST_HIST;
         end
         ST_HIST: begin
            cmd.hist = 1'b1;
            if (sts.hist_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = sts.time_adv ? ST_DIV_GO : ST_WRITE;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            cmd.div_wait = 1'b1;
            if (sts.div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // hold until the output register is free
            if (sts.out_free) begin
               cmd.write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/multi_sensor_despike_median_ema_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_sensor_despike_median_ema_unit
// Per-sensor slew limit, upper median over a short window and EMA with rate.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  req     | req_valid/req_ready   | sensor_type, sensor_id, raw_sample, time_seconds
//  rsp     | rsp_valid/rsp_ready   | filtered_level, change_rate
//  csr     | csr_write_enable      | csr_write_data (smoothing weight)
//
//  One transaction at a time. A first sample of a sensor, while a record is free, primes
//  its record and window; a later one runs the slew limit, window sort and EMA, plus the
//  serial divide when time advances. The record scan checks one key a cycle, and the
//  divider is bit-serial. Synchronous reset clears the record count, so no clearing
//  pass runs. A result waits in the output register while the next transaction is taken.
// ----------------------------------------------------------------------------
module multi_sensor_despike_median_ema_unit
   import msdme_pkg::*;
#(
   parameter int RECORDS = 32,
   parameter int WINDOW  = 5
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [TYPE_W-1:0]          req_sensor_type,
   input  logic [ID_W-1:0]            req_sensor_id,
   input  logic signed [SAMPLE_W-1:0] req_raw_sample,
   input  logic [SAMPLE_W-1:0]        req_time_seconds,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_level,
   output logic signed [SAMPLE_W-1:0] rsp_change_rate,
   input  logic                       csr_write_enable,
   input  logic [WEIGHT_W-1:0]        csr_write_data
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   msdme_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   msdme_datapath #(.RECORDS(RECORDS), .WINDOW(WINDOW)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_sensor_type    (req_sensor_type),
      .req_sensor_id      (req_sensor_id),
      .req_raw_sample     (req_raw_sample),
      .req_time_seconds   (req_time_seconds),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_filtered_level (rsp_filtered_level),
      .rsp_change_rate    (rsp_change_rate)
   );

endmodule
